### rtl/pfd_pkg.sv
// Shared types, constants and index helpers for the Playfair digraph core.
package pfd_pkg;

    localparam int unsigned SQ_DIM       = 5;
    localparam int unsigned LETTER_COUNT = 26;
    localparam int unsigned CODE_W       = 5;
    localparam int unsigned IDX_W        = 3;
    localparam int unsigned ROW_W        = SQ_DIM * CODE_W;
    localparam int unsigned CFG_IDX_W    = 3;

    typedef logic [CODE_W-1:0]    letter_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [ROW_W-1:0]     row_t;

    // [row][col] -> letter code; row r matches configuration register r
    typedef logic [SQ_DIM-1:0][SQ_DIM-1:0][CODE_W-1:0] square_t;

    localparam cfg_idx_t CFG_ROW0      = 3'd0;
    localparam cfg_idx_t CFG_ROW4      = 3'd4;
    localparam cfg_idx_t CFG_DIRECTION = 3'd5;

    localparam idx_t IDX_LAST = idx_t'(SQ_DIM - 1);

    typedef struct packed {
        letter_t first_letter;
        letter_t second_letter;
    } digraph_t;

    typedef struct packed {
        letter_t out_first;
        letter_t out_second;
        logic    pair_invalid;
    } result_t;

    typedef struct packed {
        logic found;
        idx_t row;
        idx_t col;
    } loc_t;

    // one step around the row or column, right/down for encrypt, left/up for decrypt
    function automatic idx_t step_idx(input idx_t v, input logic decrypt);
        idx_t r;
        if (decrypt) begin
            r = (v == '0) ? IDX_LAST : idx_t'(v - 1'b1);
        end else begin
            r = (v == IDX_LAST) ? '0 : idx_t'(v + 1'b1);
        end
        return r;
    endfunction

endpackage

### rtl/pfd_locate.sv
// Search lane: finds one letter code in the key square, last row-major match wins.
module pfd_locate (
    input  pfd_pkg::letter_t code,
    input  pfd_pkg::square_t square,
    output pfd_pkg::loc_t    loc
);

    always_comb
    begin
        loc = '0;
        if (code < pfd_pkg::CODE_W'(pfd_pkg::LETTER_COUNT))
        begin
            for (int r = 0; r < pfd_pkg::SQ_DIM; r++)
            begin
                for (int c = 0; c < pfd_pkg::SQ_DIM; c++)
                begin
                    if (square[r][c] == code)
                    begin
                        loc.found = 1'b1;
                        loc.row   = pfd_pkg::IDX_W'(r);
                        loc.col   = pfd_pkg::IDX_W'(c);
                    end
                end
            end
        end
    end

endmodule

### rtl/pfd_merge.sv
// Merge stage: applies the row, column or rectangle rule to the two lane results.
module pfd_merge (
    input  pfd_pkg::digraph_t digraph,
    input  pfd_pkg::loc_t     loc_a,
    input  pfd_pkg::loc_t     loc_b,
    input  pfd_pkg::square_t  square,
    input  logic              decrypt,
    output pfd_pkg::result_t  result
);

    pfd_pkg::idx_t r1, c1, r2, c2;
    pfd_pkg::idx_t r1_step, c1_step, r2_step, c2_step;

    assign r1      = loc_a.row;
    assign c1      = loc_a.col;
    assign r2      = loc_b.row;
    assign c2      = loc_b.col;
    assign r1_step = pfd_pkg::step_idx(r1, decrypt);
    assign c1_step = pfd_pkg::step_idx(c1, decrypt);
    assign r2_step = pfd_pkg::step_idx(r2, decrypt);
    assign c2_step = pfd_pkg::step_idx(c2, decrypt);

    always_comb
    begin
        result.out_first    = digraph.first_letter;
        result.out_second   = digraph.second_letter;
        result.pair_invalid = 1'b0;
        if (!loc_a.found || !loc_b.found
            || digraph.first_letter == digraph.second_letter)
        begin
            result.pair_invalid = 1'b1;
        end
        else if (r1 == r2)
        begin
            result.out_first  = square[r1][c1_step];
            result.out_second = square[r2][c2_step];
        end
        else if (c1 == c2)
        begin
            result.out_first  = square[r1_step][c1];
            result.out_second = square[r2_step][c2];
        end
        else
        begin
            result.out_first  = square[r1][c2];
            result.out_second = square[r2][c1];
        end
    end

endmodule

### rtl/playfair_digraph_cipher_core.sv
// Top level of the Playfair digraph core: key square registers, lanes, merge, output skid.
//
// Substitutes one prepared digraph (two letter codes, 0 = a .. 25 = z) per clock by the
// Playfair rules against a 5x5 key square held in configuration registers 0..4 (column 0
// in the low bits of each row) and a direction bit in register 5 (0 encrypt, 1 decrypt).
// Two search lanes locate the letters in the square side by side, and a merge stage picks
// the same-row, same-column or rectangle substitution; the whole lookup is combinational
// between the input handshake and the output register, so a new digraph is taken every
// cycle while digraph_stall is low, and its result is registered. A letter that is not in
// the square, a code above 25 or an identical pair raises pair_invalid and both letters
// pass through unchanged. A two-entry output (main register plus skid) lets the core
// accept one more digraph while a result is stalled; digraph_stall rises only when both
// entries are full. Configuration writes are always ready; writes to indexes above 5 are
// ignored, and the square should be changed only while the core is idle.
module playfair_digraph_cipher_core (
    input  logic                clk,
    input  logic                rst_n,
    // digraph channel
    input  logic                digraph_valid,
    output logic                digraph_stall,
    input  pfd_pkg::digraph_t   digraph,
    // result channel
    output logic                result_valid,
    input  logic                result_stall,
    output pfd_pkg::result_t    result,
    // configuration write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  pfd_pkg::cfg_idx_t   cfg_index,
    input  pfd_pkg::row_t       cfg_data
);

    // configuration state
    pfd_pkg::square_t square_reg, square_next;
    logic             decrypt_reg, decrypt_next;

    // output register and skid entry
    pfd_pkg::result_t out_reg, out_next;
    logic             out_valid_reg, out_valid_next;
    pfd_pkg::result_t skid_reg, skid_next;
    logic             skid_valid_reg, skid_valid_next;

    pfd_pkg::loc_t    loc_a, loc_b;
    pfd_pkg::result_t lookup;
    logic             accept;
    logic             cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        square_next  = square_reg;
        decrypt_next = decrypt_reg;
        if (cfg_write)
        begin
            if (cfg_index inside {[pfd_pkg::CFG_ROW0:pfd_pkg::CFG_ROW4]})
            begin
                square_next[cfg_index] = cfg_data;
            end
            else if (cfg_index == pfd_pkg::CFG_DIRECTION)
            begin
                decrypt_next = cfg_data[0];
            end
        end
    end

    // one search lane per letter of the digraph
    pfd_locate u_lane_first (
        .code   (digraph.first_letter),
        .square (square_reg),
        .loc    (loc_a)
    );

    pfd_locate u_lane_second (
        .code   (digraph.second_letter),
        .square (square_reg),
        .loc    (loc_b)
    );

    pfd_merge u_merge (
        .digraph (digraph),
        .loc_a   (loc_a),
        .loc_b   (loc_b),
        .square  (square_reg),
        .decrypt (decrypt_reg),
        .result  (lookup)
    );

    // stall only when the skid entry is occupied; registered, so no path from result_stall
    assign digraph_stall = skid_valid_reg;
    assign accept        = digraph_valid && !digraph_stall;

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_valid_reg && !result_stall)
        begin
            // output drained: refill from skid, then from the new item
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else if (accept)
            begin
                out_next = lookup;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg)
            begin
                out_next       = lookup;
                out_valid_next = 1'b1;
            end
            else
            begin
                // output held by downstream, park the item
                skid_next       = lookup;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            square_reg     <= '0;
            decrypt_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            square_reg     <= square_next;
            decrypt_reg    <= decrypt_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef SYNTHESIS
    // skid entry is only ever used behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // an item taken while the output is stalled must land in the skid entry
    a_park_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        accept && out_valid_reg && result_stall |=> skid_valid_reg)
        else $error("item accepted under stall was not parked");

    // a parked item moves out as soon as downstream takes the output
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !result_stall |=> !skid_valid_reg && out_valid_reg)
        else $error("skid entry did not drain");

    // after any accepted item the output register holds a valid result in the next cycle
    a_accept_visible: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted item did not reach the output");
`endif

endmodule
